@@ hw/rtl/cdll_pkg.sv @@
// shared types and codes for the cursor doubly linked list
// operation codes, result status codes, controller command and datapath status
package cdll_pkg;

    typedef enum logic [3:0] {
        MODE_CLEAR    = 4'd0,
        MODE_START    = 4'd1,
        MODE_END      = 4'd2,
        MODE_NEXT     = 4'd3,
        MODE_PREV     = 4'd4,
        MODE_GET      = 4'd5,
        MODE_INSERT   = 4'd6,
        MODE_APPEND   = 4'd7,
        MODE_REMOVE   = 4'd8,
        MODE_MOVE     = 4'd9,
        MODE_POSITION = 4'd10
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_AT_END = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
        logic step_c;
        logic walk_chk;
        logic walk_data;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic fin_a;
        logic walk;
        logic fin_b;
        logic walk_end;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/cdll_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module cdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/cdll_ctrl.sv @@
// sequencing state machine for the cursor doubly linked list
// depends on cdll_pkg for the command and status structs
module cdll_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cdll_pkg::t_sts i_sts,
    output cdll_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_A    = 7'b0000010,
        S_B    = 7'b0000100,
        S_C    = 7'b0001000,
        S_WCHK = 7'b0010000,
        S_WDAT = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_A;
            end
            S_A: begin
                o_cmd.step_a = 1'b1;
                if (i_sts.fin_a)     n_state = S_FIN;
                else if (i_sts.walk) n_state = S_WCHK;
                else                 n_state = S_B;
            end
            S_B: begin
                o_cmd.step_b = 1'b1;
                n_state = i_sts.fin_b ? S_FIN : S_C;
            end
            S_C: begin
                o_cmd.step_c = 1'b1;
                n_state = S_FIN;
            end
            S_WCHK: begin
                o_cmd.walk_chk = 1'b1;
                n_state = i_sts.walk_end ? S_FIN : S_WDAT;
            end
            S_WDAT: begin
                o_cmd.walk_data = 1'b1;
                n_state = S_WCHK;
            end
            S_FIN: begin
                o_cmd.finish = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/cdll_dp.sv @@
// datapath: node memories, sentinel links, free stack, cursor, counters, result register
// depends on cdll_pkg and cdll_ram
module cdll_dp #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32,
    parameter int IN_TW         = 48,
    parameter int OUT_TW        = 56
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cdll_pkg::t_cmd       i_cmd,
    output cdll_pkg::t_sts       o_sts,
    input  logic [IN_TW-1:0]     i_s_tdata,
    input  logic [3:0]           i_s_tuser,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [OUT_TW-1:0]    o_m_tdata
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int NW = $clog2(CAPACITY + 2);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam logic [NW-1:0] HEAD = NW'(CAPACITY);
    localparam logic [NW-1:0] TAIL = NW'(CAPACITY + 1);

    // list state
    logic [NW-1:0] r_cur, n_cur, r_hn, n_hn, r_tp, n_tp;
    logic [CW-1:0] r_free, n_free, r_low, n_low, r_cnt, n_cnt;
    // operation in flight
    cdll_pkg::t_mode   r_mode;
    logic signed [EW-1:0] r_val;
    logic [CW-1:0]     r_pos;
    logic [NW-1:0]     r_a, n_a, r_b, n_b, r_n, n_n, r_t, n_t;
    logic [CW-1:0]     r_k, n_k;
    logic signed [EW-1:0] r_vout, n_vout;
    logic [CW-1:0]     r_pout, n_pout;
    cdll_pkg::t_status r_st, n_st;
    // output register
    logic              r_ov, n_ov;
    logic [OUT_TW-1:0] r_od, n_od;

    // memory ports
    logic          el_we, nx_we, pv_we, fs_we;
    logic [SW-1:0] el_wa, nx_wa, pv_wa, fs_wa, el_ra, nx_ra, pv_ra, fs_ra;
    logic [EW-1:0] el_wd, el_rd;
    logic [NW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
    logic [SW-1:0] fs_wd, fs_rd;

    logic [CW-1:0] pop_slot;
    logic [NW-1:0] link_nx, b_node, new_node;

    cdll_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_elem (
        .i_clk(i_clk), .i_we(el_we), .i_waddr(el_wa), .i_wdata(el_wd),
        .i_raddr(el_ra), .o_rdata(el_rd)
    );
    cdll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd)
    );
    cdll_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd)
    );
    cdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd),
        .i_raddr(fs_ra), .o_rdata(fs_rd)
    );

    // free stack slots below the low-water mark were never written; their node is derived from the slot index
    assign pop_slot = r_free - CW'(1);
    assign link_nx  = (r_cur == HEAD) ? r_hn : nx_rd;
    assign b_node   = (r_mode == cdll_pkg::MODE_APPEND) ? r_b : link_nx;
    assign new_node = (pop_slot < r_low) ? (NW'(CAPACITY - 1) - NW'(pop_slot))
                                         : NW'(fs_rd);

    always_comb begin
        n_cur = r_cur; n_hn = r_hn; n_tp = r_tp;
        n_free = r_free; n_low = r_low; n_cnt = r_cnt;
        n_a = r_a; n_b = r_b; n_n = r_n; n_t = r_t; n_k = r_k;
        n_vout = r_vout; n_pout = r_pout; n_st = r_st;
        n_ov = r_ov; n_od = r_od;
        o_sts = '0;
        el_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; fs_we = 1'b0;
        el_wa = '0; nx_wa = '0; pv_wa = '0; fs_wa = '0;
        el_wd = r_val; nx_wd = '0; pv_wd = '0; fs_wd = '0;
        el_ra = '0; nx_ra = '0; pv_ra = '0; fs_ra = '0;

        o_sts.out_free = !r_ov || i_m_tready;
        if (r_ov && i_m_tready) n_ov = 1'b0;

        if (i_cmd.step_a) begin
            n_vout = '0;
            n_pout = '0;
            n_st   = cdll_pkg::ST_OK;
            nx_ra  = r_cur[SW-1:0];
            pv_ra  = r_cur[SW-1:0];
            fs_ra  = pop_slot[SW-1:0];
            case (r_mode)
                cdll_pkg::MODE_CLEAR: begin
                    n_hn = TAIL; n_tp = HEAD; n_cur = HEAD;
                    n_free = CW'(CAPACITY); n_low = CW'(CAPACITY); n_cnt = '0;
                    o_sts.fin_a = 1'b1;
                end
                cdll_pkg::MODE_START: begin
                    n_cur = HEAD;
                    o_sts.fin_a = 1'b1;
                end
                cdll_pkg::MODE_END: begin
                    n_cur = r_tp;
                    o_sts.fin_a = 1'b1;
                end
                cdll_pkg::MODE_NEXT: begin
                    if (r_cur == r_tp) begin
                        n_st = cdll_pkg::ST_AT_END;
                        o_sts.fin_a = 1'b1;
                    end else if (r_cur == HEAD) begin
                        n_cur = r_hn;
                        o_sts.fin_a = 1'b1;
                    end
                end
                cdll_pkg::MODE_PREV: begin
                    o_sts.fin_a = (r_cur == HEAD);
                end
                cdll_pkg::MODE_GET, cdll_pkg::MODE_REMOVE: begin
                end
                cdll_pkg::MODE_INSERT: begin
                    n_a = r_cur;
                    if (r_free == '0) begin
                        n_st = cdll_pkg::ST_FULL;
                        o_sts.fin_a = 1'b1;
                    end
                end
                cdll_pkg::MODE_APPEND: begin
                    n_a = r_tp;
                    n_b = TAIL;
                    if (r_free == '0) begin
                        n_st = cdll_pkg::ST_FULL;
                        o_sts.fin_a = 1'b1;
                    end
                end
                cdll_pkg::MODE_MOVE: begin
                    if (r_pos > r_cnt) begin
                        n_st = cdll_pkg::ST_RANGE;
                        o_sts.fin_a = 1'b1;
                    end else if (r_pos == '0) begin
                        n_cur = HEAD;
                        o_sts.fin_a = 1'b1;
                    end else begin
                        n_t = r_hn;
                        n_k = CW'(1);
                        o_sts.walk = 1'b1;
                    end
                end
                cdll_pkg::MODE_POSITION: begin
                    n_t = r_cur;
                    n_k = '0;
                    o_sts.walk = 1'b1;
                end
                default: o_sts.fin_a = 1'b1;
            endcase
        end

        if (i_cmd.step_b) begin
            case (r_mode)
                cdll_pkg::MODE_NEXT: begin
                    n_cur = link_nx;
                    o_sts.fin_b = 1'b1;
                end
                cdll_pkg::MODE_PREV: begin
                    n_cur = pv_rd;
                    o_sts.fin_b = 1'b1;
                end
                cdll_pkg::MODE_GET, cdll_pkg::MODE_REMOVE: begin
                    n_n   = link_nx;
                    el_ra = link_nx[SW-1:0];
                    nx_ra = link_nx[SW-1:0];
                    if (link_nx == TAIL) begin
                        n_st = cdll_pkg::ST_AT_END;
                        o_sts.fin_b = 1'b1;
                    end
                end
                cdll_pkg::MODE_INSERT, cdll_pkg::MODE_APPEND: begin
                    n_n   = new_node;
                    n_b   = b_node;
                    el_we = 1'b1; el_wa = new_node[SW-1:0]; el_wd = r_val;
                    nx_we = 1'b1; nx_wa = new_node[SW-1:0]; nx_wd = b_node;
                    pv_we = 1'b1; pv_wa = new_node[SW-1:0]; pv_wd = r_a;
                    n_free = pop_slot;
                    if (pop_slot < r_low) n_low = pop_slot;
                    n_cnt = r_cnt + CW'(1);
                end
                default: o_sts.fin_b = 1'b1;
            endcase
        end

        if (i_cmd.step_c) begin
            case (r_mode)
                cdll_pkg::MODE_GET: n_vout = el_rd;
                cdll_pkg::MODE_REMOVE: begin
                    // unlink the node after the cursor and push it on the free stack
                    n_vout = el_rd;
                    if (r_cur == HEAD) n_hn = nx_rd;
                    else begin
                        nx_we = 1'b1; nx_wa = r_cur[SW-1:0]; nx_wd = nx_rd;
                    end
                    if (nx_rd == TAIL) n_tp = r_cur;
                    else begin
                        pv_we = 1'b1; pv_wa = nx_rd[SW-1:0]; pv_wd = r_cur;
                    end
                    fs_we = 1'b1; fs_wa = r_free[SW-1:0]; fs_wd = r_n[SW-1:0];
                    n_free = r_free + CW'(1);
                    n_cnt  = r_cnt - CW'(1);
                end
                cdll_pkg::MODE_INSERT, cdll_pkg::MODE_APPEND: begin
                    if (r_a == HEAD) n_hn = r_n;
                    else begin
                        nx_we = 1'b1; nx_wa = r_a[SW-1:0]; nx_wd = r_n;
                    end
                    if (r_b == TAIL) n_tp = r_n;
                    else begin
                        pv_we = 1'b1; pv_wa = r_b[SW-1:0]; pv_wd = r_n;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.walk_chk) begin
            if (r_mode == cdll_pkg::MODE_MOVE) begin
                nx_ra = r_t[SW-1:0];
                if (r_k == r_pos) begin
                    n_cur = r_t;
                    o_sts.walk_end = 1'b1;
                end
            end else begin
                pv_ra = r_t[SW-1:0];
                if (r_t == HEAD) begin
                    n_pout = r_k;
                    o_sts.walk_end = 1'b1;
                end
            end
        end

        if (i_cmd.walk_data) begin
            n_t = (r_mode == cdll_pkg::MODE_MOVE) ? nx_rd : pv_rd;
            n_k = r_k + CW'(1);
        end

        if (i_cmd.finish) begin
            n_ov = 1'b1;
            n_od = OUT_TW'({r_st, r_cnt, r_pout, r_vout});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= HEAD;
            r_hn   <= TAIL;
            r_tp   <= HEAD;
            r_free <= CW'(CAPACITY);
            r_low  <= CW'(CAPACITY);
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_cur  <= n_cur;
            r_hn   <= n_hn;
            r_tp   <= n_tp;
            r_free <= n_free;
            r_low  <= n_low;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= cdll_pkg::t_mode'(i_s_tuser);
            r_val  <= i_s_tdata[EW-1:0];
            r_pos  <= i_s_tdata[EW +: CW];
        end
        r_a <= n_a; r_b <= n_b; r_n <= n_n; r_t <= n_t; r_k <= n_k;
        r_vout <= n_vout; r_pout <= n_pout; r_st <= n_st;
        r_od <= n_od;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;

endmodule

@@ hw/rtl/cursor_doubly_linked_list.sv @@
// top level of the cursor doubly linked list
// depends on cdll_pkg, cdll_ctrl, cdll_dp (which holds the cdll_ram node memories)

// Bounded doubly linked list with a cursor. Each input word carries one
// operation in tuser (clear, start, end, next, prev, get, insert, append,
// remove, move to position, position) and returns exactly one result word
// with the element value, position, list length and a status code. Element
// nodes live in single-port-read rams; head and tail sentinel links sit in
// flip-flops. Clear, start, end and failed checks end in step A, then the
// result hand-off; next and prev end in step B, and get, insert, append
// and remove in step C, set by the read-modify-write of the link rams (next
// from the head sentinel ends in step A, get or remove at the end in step B,
// insert or append into a full list in step A); move to position and
// position walk the links, one ram read per link followed, and move to
// position zero ends in step A. No clearing pass after reset: the free stack
// uses a low-water mark, so the block is ready at once. An input word is
// taken while a previous result still waits on the output register.
module cursor_doubly_linked_list #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input words
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // value_in, position_in
    input  logic [((ELEMENT_WIDTH + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // mode
    input  logic [3:0]          i_s_axis_tuser,
    // result words
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // value_out, position_out, list_length, status
    output logic [((ELEMENT_WIDTH + 2 * $clog2(CAPACITY + 1) + 2 + 7) / 8) * 8 - 1:0]
                                o_m_axis_tdata
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int IN_TW  = ((ELEMENT_WIDTH + CW + 7) / 8) * 8;
    localparam int OUT_TW = ((ELEMENT_WIDTH + 2 * CW + 2 + 7) / 8) * 8;

    cdll_pkg::t_cmd cmd;
    cdll_pkg::t_sts sts;

    // controller only sequences; all list state is in the datapath
    cdll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdll_dp #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .IN_TW         (IN_TW),
        .OUT_TW        (OUT_TW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

@@ hw/rtl/cdll_check.sv @@
// port-level checks for the cursor doubly linked list
// depends on cdll_pkg; bound to cursor_doubly_linked_list below
module cdll_check #(
    parameter int CAPACITY      = 256,
    parameter int ELEMENT_WIDTH = 32,
    parameter int OUT_TW        = 56
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [OUT_TW-1:0] o_m_axis_tdata
);

    localparam int EW = ELEMENT_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [EW-1:0] f_val;
    logic [CW-1:0] f_pos, f_len;
    logic [1:0]    f_st;

    assign f_val = o_m_axis_tdata[EW-1:0];
    assign f_pos = o_m_axis_tdata[EW +: CW];
    assign f_len = o_m_axis_tdata[EW + CW +: CW];
    assign f_st  = o_m_axis_tdata[EW + 2 * CW +: 2];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> f_len <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_err_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && f_st != cdll_pkg::ST_OK |-> f_val == '0)
        else $error("error result carries a value");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && f_st == cdll_pkg::ST_FULL |-> f_len == CW'(CAPACITY))
        else $error("full status with room left");

    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> f_pos <= f_len)
        else $error("position beyond list length");

endmodule

bind cursor_doubly_linked_list cdll_check #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .OUT_TW        (OUT_TW)
) u_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
